[rtl/lht_pkg.sv]
// Shared types and codes for the LRU hash table.
package lht_pkg;

    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    localparam logic [1:0] MODE_ANY     = 2'd0;
    localparam logic [1:0] MODE_ABSENT  = 2'd1;
    localparam logic [1:0] MODE_PRESENT = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EXISTS    = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key;
        logic [63:0] new_value;
        logic [1:0]  update_mode;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_value;
        logic        evicted;
    } rsp_t;

endpackage

[rtl/lht_match.sv]
// Parallel key compare, LRU slot select and free-slot priority pick.
module lht_match #(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 64,
    parameter int RANK_BITS = 4
) (
    input  logic [ENTRIES-1:0]   valid_vec,
    input  logic [KEY_BITS-1:0]  key_arr [ENTRIES],
    input  logic [RANK_BITS-1:0] rank_arr [ENTRIES],
    input  logic [KEY_BITS-1:0]  key,
    input  logic [RANK_BITS-1:0] lru_rank,
    input  logic [ENTRIES-1:0]   avail_vec,
    output logic [ENTRIES-1:0]   hit_vec,
    output logic [RANK_BITS-1:0] hit_rank,
    output logic [ENTRIES-1:0]   lru_vec,
    output logic [ENTRIES-1:0]   pick_vec
);

    always_comb begin
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = valid_vec[i] && (key_arr[i] == key);
            lru_vec[i] = valid_vec[i] && (rank_arr[i] == lru_rank);
            hit_rank   = hit_rank | (rank_arr[i] & {RANK_BITS{hit_vec[i]}});
        end
    end

    // lowest set bit
    assign pick_vec = avail_vec & (~avail_vec + ENTRIES'(1));

endmodule

[rtl/lht_store.sv]
// Slot storage, recency ranks and per-operation update logic.
module lht_store #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          exec,
    input  lht_pkg::req_t                 req,
    input  logic [lht_pkg::CAP_BITS-1:0]  cap,
    output lht_pkg::rsp_t                 rsp
);
    import lht_pkg::*;

    localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int LIM_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [RANK_BITS-1:0]  rank_reg [ENTRIES];
    logic [RANK_BITS-1:0]  rank_next [ENTRIES];
    logic [KEY_BITS-1:0]   key_reg [ENTRIES];
    logic [VALUE_BITS-1:0] value_reg [ENTRIES];
    logic [CNT_BITS-1:0]   live_reg, live_next;

    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    logic [CNT_BITS-1:0]   live_m1;
    logic [RANK_BITS-1:0]  lru_rank, hit_rank;
    logic [ENTRIES-1:0]    hit_vec, lru_vec, avail_vec, pick_vec, kept_vec, wr_vec;
    logic [VALUE_BITS-1:0] hit_value;
    logic [CAP_BITS-1:0]   cap1;
    logic                  hit, evict;
    logic                  do_touch, do_remove, do_insert, do_overwrite;

    assign req_key   = req.key[KEY_BITS-1:0];
    assign req_value = req.new_value[VALUE_BITS-1:0];
    assign live_m1   = live_reg - CNT_BITS'(1);
    assign lru_rank  = live_m1[RANK_BITS-1:0];

    // limit of zero behaves as one; above ENTRIES is covered by the all-valid term
    assign cap1  = (cap == '0) ? CAP_BITS'(1) : cap;
    assign evict = (&valid_reg) || (LIM_BITS'(live_reg) >= LIM_BITS'(cap1));

    assign avail_vec = ~valid_reg | (evict ? lru_vec : '0);
    assign kept_vec  = valid_reg & ~(evict ? lru_vec : '0);
    assign hit       = |hit_vec;

    lht_match #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .RANK_BITS (RANK_BITS)
    ) u_match (
        .valid_vec (valid_reg),
        .key_arr   (key_reg),
        .rank_arr  (rank_reg),
        .key       (req_key),
        .lru_rank  (lru_rank),
        .avail_vec (avail_vec),
        .hit_vec   (hit_vec),
        .hit_rank  (hit_rank),
        .lru_vec   (lru_vec),
        .pick_vec  (pick_vec)
    );

    always_comb begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_value = hit_value | (value_reg[i] & {VALUE_BITS{hit_vec[i]}});
        end
    end

    // operation decode and result
    always_comb begin
        rsp          = '0;
        rsp.status   = ST_OK;
        do_touch     = 1'b0;
        do_remove    = 1'b0;
        do_insert    = 1'b0;
        do_overwrite = 1'b0;
        case (req.func)
            FUNC_LOOKUP: begin
                if (hit) begin
                    rsp.read_value = 64'(hit_value);
                    do_touch       = 1'b1;
                end else begin
                    rsp.status = ST_NOT_FOUND;
                end
            end
            FUNC_UPDATE: begin
                if (req.update_mode == MODE_INVALID) begin
                    rsp.status = ST_INVALID;
                end else if (hit) begin
                    if (req.update_mode == MODE_ABSENT) begin
                        rsp.status = ST_EXISTS;
                    end else begin
                        do_overwrite = 1'b1;
                        do_touch     = 1'b1;
                    end
                end else if (req.update_mode == MODE_PRESENT) begin
                    rsp.status = ST_NOT_FOUND;
                end else begin
                    do_insert   = 1'b1;
                    rsp.evicted = evict;
                end
            end
            FUNC_DELETE: begin
                if (hit) begin
                    do_remove = 1'b1;
                end else begin
                    rsp.status = ST_NOT_FOUND;
                end
            end
            default: begin
                rsp.status = ST_INVALID;
            end
        endcase
    end

    // rank maintenance: ranks of live slots are always 0 .. live-1
    always_comb begin
        valid_next = valid_reg;
        live_next  = live_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (exec && do_touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (hit_vec[i]) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                    rank_next[i] = rank_reg[i] + RANK_BITS'(1);
                end
            end
        end
        if (exec && do_remove) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (hit_vec[i]) begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end else if (valid_reg[i] && (rank_reg[i] > hit_rank)) begin
                    rank_next[i] = rank_reg[i] - RANK_BITS'(1);
                end
            end
            live_next = live_m1;
        end
        if (exec && do_insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (pick_vec[i]) begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end else if (kept_vec[i]) begin
                    rank_next[i] = rank_reg[i] + RANK_BITS'(1);
                end else if (valid_reg[i]) begin
                    // evicted slot not reused
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
            end
            live_next = evict ? live_reg : live_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            live_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            live_reg  <= live_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    assign wr_vec = do_insert ? pick_vec : (do_overwrite ? hit_vec : '0);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (exec && wr_vec[i]) begin
                value_reg[i] <= req_value;
                if (do_insert) begin
                    key_reg[i] <= req_key;
                end
            end
        end
    end

    a_live_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == live_reg)
        else $error("live count out of step with valid slots");

    a_hit_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("key matches more than one slot");

    a_evict_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && rsp.evicted |=> live_reg == $past(live_reg))
        else $error("eviction changed live count");

endmodule

[rtl/lru_hash_table.sv]
// Top level of the LRU hash table: stream handshake, config port, storage.
// Keyed store of ENTRIES slots with least-recently-used replacement. Each
// input beat is a lookup, update or delete of one key; each produces exactly
// one result beat, held first in the input register and then in the result
// register. Throughput is one beat per clock while m_ready keeps the result
// register draining: the whole key search is a combinational compare
// against every slot in parallel, with state updated in the same cycle, so
// back-to-back beats see each other's effects. Both channels are valid/ready;
// an input register and a result register decouple the two sides. Register
// 0 (byte address 0) is capacity_limit, 5 bits, reset 16; a value of 0 acts
// as 1 and values above ENTRIES act as ENTRIES. Change it only while the
// block is idle. The table is empty after reset; no clearing pass is needed.
module lru_hash_table #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    // input beats
    input  logic          s_valid,
    output logic          s_ready,
    input  lht_pkg::req_t s_data,
    // result beats
    output logic          m_valid,
    input  logic          m_ready,
    output lht_pkg::rsp_t m_data,
    // config port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import lht_pkg::*;

    localparam logic REG_CAPACITY = 1'b0;

    req_t                req_reg;
    logic                req_valid_reg, req_valid_next;
    rsp_t                rsp_reg, rsp;
    logic                m_valid_reg, m_valid_next;
    logic [CAP_BITS-1:0] cap_reg;
    logic                out_free, exec, s_fire, cfg_wr;

    // an item executes when the result register is free or draining this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign exec     = req_valid_reg && out_free;
    assign s_ready  = !req_valid_reg || exec;
    assign s_fire   = s_valid && s_ready;

    assign req_valid_next = s_fire ? 1'b1 : (exec ? 1'b0 : req_valid_reg);
    assign m_valid_next   = exec ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= s_data;
        end
        if (exec) begin
            rsp_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            cap_reg <= pwdata[CAP_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = 32'(cap_reg);
        end
    end

    lht_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (exec),
        .req     (req_reg),
        .cap     (cap_reg),
        .rsp     (rsp)
    );

    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> m_valid_reg)
        else $error("executed beat produced no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !exec)
        else $error("result register overwritten while stalled");

    a_accept_when_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid_reg && !exec |-> !s_ready)
        else $error("input register overrun");

endmodule

[dv/tb.sv]
// Testbench for lru_hash_table: shadow LRU table, directed and random beats, APB config phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lht_pkg::*;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_KEYS   = 32;

    // func value the block does not define; must answer invalid with no state change
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    // register map: capacity_limit at byte 0, nothing behind byte 4
    localparam logic [2:0] CAP_ADDR   = 3'd0;
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    // Shadow copy of the table. Every accepted request beat is applied here in
    // acceptance order, and the result it must produce is queued for the
    // response side.
    class lru_shadow;
        logic                live [SLOTS];
        logic [63:0]         keys [SLOTS];
        logic [63:0]         vals [SLOTS];
        int unsigned         rank [SLOTS];   // 0 = most recent
        int unsigned         used;
        logic [CAP_BITS-1:0] cap;
        rsp_t                awaited [$];
        int unsigned         mismatches;

        function new();
            cap        = CAP_RESET;
            used       = 0;
            mismatches = 0;
            foreach (live[i]) begin
                live[i] = 1'b0;
                keys[i] = '0;
                vals[i] = '0;
                rank[i] = 0;
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function int vacant();
            for (int i = 0; i < SLOTS; i++)
                if (!live[i]) return i;
            return -1;
        endfunction

        function void promote(int s);
            int unsigned r0;
            r0 = rank[s];
            for (int i = 0; i < SLOTS; i++)
                if (live[i] && rank[i] < r0) rank[i]++;
            rank[s] = 0;
        endfunction

        function void drop(int s);
            int unsigned r0;
            r0 = rank[s];
            for (int i = 0; i < SLOTS; i++)
                if (live[i] && i != s && rank[i] > r0) rank[i]--;
            live[s] = 1'b0;
            rank[s] = 0;
            if (used > 0) used--;
        endfunction

        function void accept_request(req_t rq);
            rsp_t        r;
            int          s;
            int          lru;
            int unsigned lim;
            r = '0;
            s = -1;
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && live[i] && keys[i] == rq.key) s = i;
            case (rq.func)
                FUNC_LOOKUP: begin
                    if (s < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.read_value = vals[s];
                        promote(s);
                    end
                end
                FUNC_UPDATE: begin
                    // mode is checked before the key
                    if (rq.update_mode == MODE_INVALID) begin
                        r.status = ST_INVALID;
                    end else if (rq.update_mode == MODE_ABSENT && s >= 0) begin
                        r.status = ST_EXISTS;
                    end else if (rq.update_mode == MODE_PRESENT && s < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else if (s >= 0) begin
                        vals[s] = rq.new_value;
                        promote(s);
                    end else begin
                        // limit 0 acts as 1, anything above the slot count as full size
                        lim = (cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : int'(cap);
                        if (used >= lim || vacant() < 0) begin
                            lru = -1;
                            for (int i = 0; i < SLOTS; i++)
                                if (live[i] && (lru < 0 || rank[i] > rank[lru])) lru = i;
                            if (lru >= 0) begin
                                drop(lru);
                                r.evicted = 1'b1;
                            end
                        end
                        s = vacant();
                        if (s >= 0) begin
                            for (int i = 0; i < SLOTS; i++)
                                if (live[i]) rank[i]++;
                            live[s] = 1'b1;
                            keys[s] = rq.key;
                            vals[s] = rq.new_value;
                            rank[s] = 0;
                            used++;
                        end
                    end
                end
                FUNC_DELETE: begin
                    if (s < 0) r.status = ST_NOT_FOUND;
                    else drop(s);
                end
                default: r.status = ST_INVALID;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp;
            if (awaited.size() == 0) begin
                $error("result beat with nothing outstanding: %h", got);
                mismatches++;
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatches++;
            end
            if (got.read_value !== exp.read_value) begin
                $error("read_value: expected %h, got %h", exp.read_value, got.read_value);
                mismatches++;
            end
            if (got.evicted !== exp.evicted) begin
                $error("evicted: expected %0d, got %0d", exp.evicted, got.evicted);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    req_t        s_data;
    logic        m_valid;
    logic        m_ready;
    rsp_t        m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lru_shadow   shadow = new();
    int unsigned cycles = 0;

    // traffic knobs, changed by the main sequence between phases
    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_len;          // one-shot long receiver hold, in cycles
    int unsigned span;              // how many pool keys the random beats draw from
    logic [63:0] key_pool [POOL_KEYS];

    lru_hash_table dut (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Both channels sampled at the rising edge. The result side is checked
    // first; a result leaving at this edge never belongs to the beat entering
    // at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) shadow.check_response(m_data);
            if (s_valid && s_ready) shadow.accept_request(s_data);
        end
    end

    // Receiver: random stalls at the current rate, plus a long hold when the
    // main sequence asks for one. The hold is counted here, so the sender keeps
    // offering beats until the block backs up.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_len != 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_len = 0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One request beat. Optional idle gap first (valid low), then valid held
    // with a stable payload until the edge that takes it. A back-to-back beat
    // keeps valid high across the boundary.
    task automatic send_req(req_t rq);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_op(logic [1:0] f, logic [63:0] k, logic [63:0] v, logic [1:0] m);
        req_t rq;
        rq.func        = f;
        rq.key         = k;
        rq.new_value   = v;
        rq.update_mode = m;
        send_req(rq);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Sender pause: wait out every outstanding result.
    task automatic wait_idle();
        while (shadow.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup then access; pready is tied high so the access needs no wait states.
    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CAP_ADDR) shadow.cap = data[CAP_BITS-1:0];
    endtask

    // APB read of capacity_limit, compared against the value last written, or the reset value.
    task automatic cfg_check(logic [CAP_BITS-1:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAP_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[CAP_BITS-1:0] !== want) begin
            $error("capacity_limit: expected %0d, got %0d", want, prdata[CAP_BITS-1:0]);
            shadow.mismatches++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly pool keys so hits, overwrites and evictions are common; some
    // fully random keys for misses. Occasional invalid modes and unknown funcs.
    function automatic req_t random_req();
        req_t        rq;
        int unsigned pick;
        pick = $urandom_range(99);
        rq.func = (pick < 40) ? FUNC_LOOKUP :
                  (pick < 78) ? FUNC_UPDATE :
                  (pick < 95) ? FUNC_DELETE : FUNC_UNKNOWN;
        rq.update_mode = ($urandom_range(99) < 88) ? 2'($urandom_range(2)) : MODE_INVALID;
        rq.key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(span - 1)]
                                           : {$urandom, $urandom};
        rq.new_value = {$urandom, $urandom};
        return rq;
    endfunction

    // Idle block, new limit, readback, then a burst of random beats.
    task automatic run_phase(logic [31:0] cap_word, int unsigned idle_pct,
                             int unsigned stall_pct, int unsigned keys_used,
                             int unsigned count);
        wait_idle();
        cfg_write(CAP_ADDR, cap_word);
        cfg_check(cap_word[CAP_BITS-1:0]);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        span            = keys_used;
        repeat (count) send_req(random_req());
        stop_sending();
    endtask

    initial begin
        s_valid         = 1'b0;
        s_data          = '0;
        m_ready         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        aresetn         = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_len        = 0;
        span            = 24;

        // extremes and single-bit near misses up front, random keys after
        key_pool[0] = '1;
        key_pool[1] = '0;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'h0000_0000_0000_0001;
        for (int i = 4; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        cfg_check(CAP_RESET);

        // --- directed: empty table ---
        send_op(FUNC_LOOKUP, key_pool[1], '0, MODE_ANY);          // miss
        send_op(FUNC_DELETE, key_pool[1], '0, MODE_ANY);          // not found
        send_op(FUNC_UPDATE, key_pool[1], '1, MODE_PRESENT);      // not found
        send_op(FUNC_UPDATE, key_pool[1], '1, MODE_INVALID);      // invalid mode
        send_op(FUNC_UNKNOWN, key_pool[1], '1, MODE_ANY);         // unknown func
        // insert-if-absent, then again on the same key, then hit
        send_op(FUNC_UPDATE, key_pool[0], '1, MODE_ABSENT);
        send_op(FUNC_UPDATE, key_pool[0], '0, MODE_ABSENT);       // exists
        send_op(FUNC_LOOKUP, key_pool[0], '0, MODE_ANY);          // all-ones value back
        // fill to 16, the 17th insert evicts the oldest (the all-ones key)
        for (int i = 1; i <= 16; i++)
            send_op(FUNC_UPDATE, key_pool[i], {$urandom, $urandom}, MODE_ANY);
        send_op(FUNC_DELETE, key_pool[1], '0, MODE_ANY);
        stop_sending();

        // --- random phases, one limit each ---
        run_phase(32'd16, 0, 0, 24, 200);              // no idling, table full
        run_phase(32'hFFFF_FFE3, 71, 0, 8, 120);       // limit 3 below live count; junk upper bits
        run_phase(32'd0, 0, 71, 4, 100);               // limit 0 acts as 1
        wait_idle();                                   // drain first so the hold overlaps sending
        hold_len = 400;                                // long receiver hold, sender keeps pushing
        run_phase(32'd31, 0, 0, 24, 60);               // limit above slot count
        run_phase(32'd31, 31, 31, 24, 140);
        wait_idle();
        cfg_write(SPARE_ADDR, $urandom);               // unmapped address, no effect
        run_phase(32'd1, 31, 31, 3, 100);
        run_phase(32'd8, 0, 0, 14, 150);
        run_phase(32'd16, 71, 71, 20, 100);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (shadow.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[lru_hash_table.f]
rtl/lht_pkg.sv
rtl/lht_match.sv
rtl/lht_store.sv
rtl/lru_hash_table.sv
dv/tb.sv
